// ----- rtl/core/fwss_pkg.sv -----
package fwss_pkg;

  // storage and field widths
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned SUM_W = 42;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned LEN_W = 11;
  localparam int unsigned ACT_W = 2;

  localparam int unsigned IN_BITS     = VAL_W + LEN_W + SUM_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS    = 1 + IDX_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic append;
    logic load;
    logic probe;
    logic sub;
    logic step_lo;
    logic step_hi;
    logic res_load;
    logic res_found;
  } fwss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
    logic last_probe;
    logic lt;
    logic eq;
  } fwss_stat_t;

endpackage

// ----- rtl/core/fwss_dp.sv -----
module fwss_dp
  import fwss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fwss_cmd_t        cmd_i,
  output fwss_stat_t       stat_o,
  input  logic [VAL_W-1:0] value_i,
  input  logic [LEN_W-1:0] len_i,
  input  logic [SUM_W-1:0] target_i,
  output logic             found_o,
  output logic [IDX_W-1:0] start_index_o
);

  // prefix sum memory, one write and two read ports
  logic [SUM_W-1:0] mem_q [DEPTH];

  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] total_q, total_d;
  logic [SUM_W-1:0] sum_add;

  logic [LEN_W-1:0] len_q;
  logic [SUM_W-1:0] target_q;
  logic             bad_q;
  logic [IDX_W-1:0] lo_q, hi_q;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic             last_q;
  logic             has_before_q;
  logic [SUM_W-1:0] rd_last_q, rd_before_q;
  logic [SUM_W-1:0] sum_q;
  logic             found_q;
  logic [IDX_W-1:0] idx_q;

  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] addr_last, addr_before;
  logic [CNT_W-1:0] hi_init;
  logic             full;

  assign full    = (count_q == CNT_W'(DEPTH));
  assign sum_add = total_q + SUM_W'(value_i);

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    if (cmd_i.clear) begin
      count_d = '0;
      total_d = '0;
    end else if (cmd_i.append && !full) begin
      count_d = count_q + CNT_W'(1);
      total_d = sum_add;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
    end else begin
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      mem_q[count_q[IDX_W-1:0]] <= sum_add;
    end
  end

  // probe position: mid of the range, or hi once the range is one wide
  assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q} + (IDX_W+1)'(1);
  assign pos_d       = (lo_q == hi_q) ? hi_q : mid_sum[IDX_W:1];
  assign addr_last   = pos_d + len_q[IDX_W-1:0] - IDX_W'(1);
  assign addr_before = pos_d - IDX_W'(1);
  assign hi_init     = count_q - len_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe) begin
      rd_last_q   <= mem_q[addr_last];
      rd_before_q <= mem_q[addr_before];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      len_q    <= len_i;
      target_q <= target_i;
      bad_q    <= (len_i == '0) || (len_i > count_q);
      lo_q     <= '0;
      hi_q     <= hi_init[IDX_W-1:0];
    end else if (cmd_i.step_lo) begin
      lo_q <= pos_q;
    end else if (cmd_i.step_hi) begin
      hi_q <= pos_q - IDX_W'(1);
    end
    if (cmd_i.probe) begin
      pos_q        <= pos_d;
      last_q       <= (lo_q == hi_q);
      has_before_q <= (pos_d != '0);
    end
    if (cmd_i.sub) begin
      sum_q <= rd_last_q - (has_before_q ? rd_before_q : '0);
    end
    if (cmd_i.res_load) begin
      found_q <= cmd_i.res_found;
      idx_q   <= cmd_i.res_found ? pos_q : '0;
    end
  end

  assign stat_o.bad        = bad_q;
  assign stat_o.last_probe = last_q;
  assign stat_o.lt         = (sum_q < target_q);
  assign stat_o.eq         = (sum_q == target_q);

  assign found_o       = found_q;
  assign start_index_o = idx_q;

endmodule

// ----- rtl/core/fwss_ctrl.sv -----
module fwss_ctrl
  import fwss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic [ACT_W-1:0] action_i,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  input  fwss_stat_t       stat_i,
  output fwss_cmd_t        cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_PROBE = 3'd2;
  localparam logic [2:0] ST_SUB   = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || m_ready_i;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          case (action_i)
            ACT_CLEAR:  cmd_o.clear  = 1'b1;
            ACT_APPEND: cmd_o.append = 1'b1;
            ACT_QUERY: begin
              cmd_o.load = 1'b1;
              state_d    = ST_START;
            end
            default: ;
          endcase
        end
      end
      ST_START: begin
        if (stat_i.bad) begin
          if (out_free) begin
            cmd_o.res_load = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd_o.probe = 1'b1;
        state_d     = ST_SUB;
      end
      ST_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        if (stat_i.eq || stat_i.last_probe) begin
          // hold here until the output word is free
          if (out_free) begin
            cmd_o.res_load  = 1'b1;
            cmd_o.res_found = stat_i.eq;
            state_d         = ST_IDLE;
          end
        end else if (stat_i.lt) begin
          cmd_o.step_lo = 1'b1;
          state_d       = ST_PROBE;
        end else begin
          cmd_o.step_hi = 1'b1;
          state_d       = ST_PROBE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

// ----- rtl/core/fixed_window_sum_search.sv -----
// clear and append words act on acceptance and leave the sequencer idle; a query word needs
// p probes of the prefix memory from accept to result, at most log2(depth) + 1 (11)
// one word at a time, next word accepted the cycle after the result loads
// every probe runs a dual port memory read, then the window subtract, then the compare
// reset clears element count, running total, controller and output valid at once;
// the prefix memory is not cleared, only entries below the element count feed a result
module fixed_window_sum_search
  import fwss_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave side
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata: value [31:0], window_length [42:32], target_sum [84:43], zero pad [87:85]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: action [1:0]
  input  logic [ACT_W-1:0]       s_axis_tuser_i,
  // master side
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // tdata: found [0], start_index [10:1], zero pad [15:11]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  fwss_cmd_t        cmd;
  fwss_stat_t       stat;
  logic [VAL_W-1:0] in_value;
  logic [LEN_W-1:0] in_len;
  logic [SUM_W-1:0] in_target;
  logic             res_found;
  logic [IDX_W-1:0] res_index;

  // unpack the input word
  assign in_value  = s_axis_tdata_i[VAL_W-1:0];
  assign in_len    = s_axis_tdata_i[VAL_W+LEN_W-1:VAL_W];
  assign in_target = s_axis_tdata_i[IN_BITS-1:VAL_W+LEN_W];

  // sequencer: one word in flight, output register decoupled from the input side
  fwss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .action_i  (s_axis_tuser_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // prefix memory, running total, search bounds and result register
  fwss_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .value_i       (in_value),
    .len_i         (in_len),
    .target_i      (in_target),
    .found_o       (res_found),
    .start_index_o (res_index)
  );

  // pack the result word
  assign m_axis_tdata_o = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, res_index, res_found};

endmodule

// ----- verif/fixed_window_sum_search_test.sv -----
module fixed_window_sum_search_test;
  import fwss_pkg::*;

  // action code the block has to ignore
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int unsigned RANDOM_WORDS = 50;
  // slowest query makes 11 probes of the store, leave some slack
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned REPORT_CAP = 30;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] start_index;
  } search_result_t;

  // predictor of the block plus the queue of results still owed by it
  class window_search_board;
    logic [SUM_W-1:0] prefix_sums [DEPTH];
    int unsigned      elem_count = 0;
    logic [SUM_W-1:0] run_total = '0;
    search_result_t   pending_results [$];
    int unsigned      mismatches = 0;
    int unsigned      results_checked = 0;
    int unsigned      hits = 0;

    // caller keeps len >= 1 and start + len <= elem_count
    function logic [SUM_W-1:0] window_total(int unsigned start, int unsigned len);
      logic [SUM_W-1:0] head;
      head = (start == 0) ? '0 : prefix_sums[start-1];
      return prefix_sums[start+len-1] - head;
    endfunction

    // binary search over start positions, early exit on an exact hit
    function search_result_t predict_search(int unsigned len, logic [SUM_W-1:0] target);
      search_result_t   res;
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      mid;
      logic [SUM_W-1:0] probe;
      res = '0;
      if (len == 0 || len > elem_count) return res;
      lo = 0;
      hi = elem_count - len;
      while (lo != hi) begin
        mid = (lo + hi + 1) / 2;
        probe = window_total(mid, len);
        if (probe < target) begin
          lo = mid;
        end else if (probe == target) begin
          res.found = 1'b1;
          res.start_index = mid[IDX_W-1:0];
          return res;
        end else begin
          hi = mid - 1;
        end
      end
      if (window_total(hi, len) == target) begin
        res.found = 1'b1;
        res.start_index = hi[IDX_W-1:0];
      end
      return res;
    endfunction

    function void note_word(logic [ACT_W-1:0] act, logic [VAL_W-1:0] val,
                            logic [LEN_W-1:0] len, logic [SUM_W-1:0] target);
      case (act)
        ACT_CLEAR: begin
          elem_count = 0;
          run_total = '0;
        end
        ACT_APPEND: begin
          // a full store drops the word, total untouched
          if (elem_count < DEPTH) begin
            run_total = run_total + SUM_W'(val);
            prefix_sums[elem_count] = run_total;
            elem_count++;
          end
        end
        ACT_QUERY: begin
          pending_results.push_back(predict_search(len, target));
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] word);
      search_result_t want;
      logic           got_found;
      logic [IDX_W-1:0] got_index;
      got_found = word[0];
      got_index = word[IDX_W:1];
      if (pending_results.size() == 0) begin
        report_mismatch("result with no query pending", word, 0);
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (want.found) hits++;
      if (got_found !== want.found) report_mismatch("found", got_found, want.found);
      if (got_index !== want.start_index)
        report_mismatch("start_index", got_index, want.start_index);
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // tdata: value, window_length, target_sum, zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  // tuser: action
  logic [ACT_W-1:0]       s_axis_tuser_i = ACT_CLEAR;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // tdata: found, start_index, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  window_search_board board = new();

  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned useful_words = 0;
  int unsigned drain_pauses = 0;
  int unsigned max_fill = 0;
  bit          quiet_tail = 1'b0;

  fixed_window_sum_search u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit with %0d results outstanding",
               board.pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: check every accepted word, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) board.check_result(m_axis_tdata_o);
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 8);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // present one word, hold it until accepted, then maybe idle for a burst
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
                           input logic [LEN_W-1:0] len, input logic [SUM_W-1:0] target);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= act;
    s_axis_tdata_i <= IN_TDATA_W'({target, len, val});
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (act != ACT_UNUSED && !(act == ACT_APPEND && board.elem_count == DEPTH))
      useful_words++;
    board.note_word(act, val, len, target);
    if (board.elem_count > max_fill) max_fill = board.elem_count;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // sender goes quiet until every owed result has come back
  task automatic hold_until_drained();
    s_axis_tvalid_i <= 1'b0;
    drain_pauses++;
    do @(posedge clk_i); while (board.pending_results.size() != 0);
  endtask

  // often sums that really occur in the store, some near misses and noise
  function automatic logic [SUM_W-1:0] pick_target(int unsigned len);
    int unsigned      pick;
    int unsigned      start;
    logic [SUM_W-1:0] real_sum;
    pick = $urandom_range(0, 19);
    if (len == 0 || len > board.elem_count || pick >= 15)
      return pick[0] ? SUM_W'({$urandom, $urandom}) : SUM_W'($urandom_range(0, 64));
    start = $urandom_range(0, board.elem_count - len);
    real_sum = board.window_total(start, len);
    if (pick >= 12) return real_sum + 1'b1;
    if (pick >= 9) return real_sum - 1'b1;
    return real_sum;
  endfunction

  initial begin : stimulus
    int unsigned     start_words;
    int unsigned     runs;
    int unsigned     mode;
    int unsigned     cnt;
    int unsigned     len;
    longint unsigned level;
    longint unsigned step_cap;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store: nothing can be found, zero or nonzero length
    send_word(ACT_QUERY, '0, '0, '0);
    send_word(ACT_QUERY, '0, 11'd1, '0);
    // short nondecreasing run holding both value extremes
    send_word(ACT_APPEND, 32'd0, '0, '0);
    send_word(ACT_APPEND, 32'd3, '0, '0);
    send_word(ACT_APPEND, 32'd5, '0, '0);
    send_word(ACT_APPEND, '1, '0, '0);
    // narrowing down to the first position, then the final check hits
    send_word(ACT_QUERY, '0, 11'd1, 42'd0);
    // exact hit on an early probe
    send_word(ACT_QUERY, '0, 11'd2, 42'd8);
    // window as long as the store: a single position, only the final check
    send_word(ACT_QUERY, '0, 11'd4, 42'h1_0000_0007);
    send_word(ACT_QUERY, '0, 11'd1, 42'hFFFF_FFFF);
    // plain miss, too long, empty window, every field at its top
    send_word(ACT_QUERY, '0, 11'd1, 42'd4);
    send_word(ACT_QUERY, '0, 11'd5, 42'd0);
    send_word(ACT_QUERY, '0, 11'd0, 42'd0);
    send_word(ACT_QUERY, '1, '1, '1);
    // unused action code must leave the store alone
    send_word(ACT_UNUSED, '1, 11'd1, '1);
    send_word(ACT_QUERY, '0, 11'd4, 42'h1_0000_0007);
    // clear with junk in every other field
    send_word(ACT_CLEAR, '1, '1, '1);
    send_word(ACT_QUERY, '0, 11'd1, 42'd0);
    send_word(ACT_APPEND, 32'h8000_0000, '0, '0);
    send_word(ACT_QUERY, '0, 11'd1, 42'h8000_0000);
    send_word(ACT_QUERY, '0, 11'h400, 42'h8000_0000);
    hold_until_drained();

    // fill the store to the brim with large nondecreasing values
    send_word(ACT_CLEAR, '0, '0, '0);
    level = 64'd202_967_295;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      send_word(ACT_APPEND, (i >= DEPTH - 24) ? '1 : level[VAL_W-1:0],
                LEN_W'($urandom), SUM_W'({$urandom, $urandom}));
      level += $urandom_range(0, 4_000_000);
    end
    // appends past the top are dropped
    repeat (3) send_word(ACT_APPEND, $urandom, '0, '0);
    send_word(ACT_QUERY, '0, 11'd1024, board.window_total(0, DEPTH));
    send_word(ACT_QUERY, '0, 11'd1024, board.window_total(0, DEPTH) - 1'b1);
    send_word(ACT_QUERY, '0, 11'd1025, '0);
    send_word(ACT_QUERY, '0, '1, '1);
    send_word(ACT_QUERY, '0, 11'd1, board.window_total(DEPTH - 1, 1));
    send_word(ACT_QUERY, '0, 11'd1, '1);
    repeat (16) begin
      len = $urandom_range(1, DEPTH);
      send_word(ACT_QUERY, '0, LEN_W'(len), pick_target(len));
    end
    hold_until_drained();

    // random part: runs of appends followed by queries, with some noise
    start_words = useful_words;
    while (useful_words - start_words < RANDOM_WORDS) begin
      if (useful_words - start_words >= RANDOM_WORDS * 4 / 5) quiet_tail = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_word(ACT_W'($urandom_range(0, 3)), $urandom, LEN_W'($urandom),
                    SUM_W'({$urandom, $urandom}));
      end else begin
        if ($urandom_range(0, 3) != 0) send_word(ACT_CLEAR, $urandom, '0, '0);
        runs = ($urandom_range(0, 6) == 0) ? $urandom_range(49, 160) : $urandom_range(1, 48);
        // 0 rising, 1 constant, 2 unordered, 3 slowly rising small values
        mode = $urandom_range(0, 3);
        level = (mode == 3) ? 64'($urandom_range(0, 8)) : 64'($urandom >> $urandom_range(0, 31));
        step_cap = (mode == 3) ? 64'd3 : 64'($urandom >> $urandom_range(4, 31));
        repeat (runs) begin
          send_word(ACT_APPEND, (mode == 2) ? $urandom : level[VAL_W-1:0], '0, '0);
          if (mode != 1) level += $urandom_range(0, step_cap);
          if (level > 64'hFFFF_FFFF) level = 64'hFFFF_FFFF;
        end
        repeat ($urandom_range(2, 8)) begin
          cnt = board.elem_count;
          case ($urandom_range(0, 9))
            0: len = 0;
            1: len = $urandom_range(cnt + 1, 2047);
            2: len = $urandom_range(0, 2047);
            default: len = (cnt == 0) ? 1 : $urandom_range(1, cnt);
          endcase
          send_word(ACT_QUERY, $urandom, LEN_W'(len), pick_target(len));
        end
        if (!quiet_tail && $urandom_range(0, 5) == 0) hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d effective words, checked %0d query results, %0d of them hits",
             useful_words, board.results_checked, board.hits);
    $display("store reached %0d entries, sender drained the block %0d times",
             max_fill, drain_pauses);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/fwss_pkg.sv
rtl/core/fwss_dp.sv
rtl/core/fwss_ctrl.sv
rtl/core/fixed_window_sum_search.sv
verif/fixed_window_sum_search_test.sv
